/* design/rmq_pkg.sv */
// Shared constants and width helpers for the rotation matrix to quaternion block.
package rmq_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 14;
  localparam int NUM_LANES  = 3;

  // Index of the winning candidate term
  typedef enum logic [1:0] {
    BIG_X = 2'd0,
    BIG_Y = 2'd1,
    BIG_Z = 2'd2,
    BIG_W = 2'd3
  } big_t;

  // Width of a candidate term (three elements plus one, signed)
  function automatic int term_w(input int w, input int f);
    return ((w > f) ? w : f + 1) + 2;
  endfunction

  // Bits of the nonnegative radicand term << (f-2)
  function automatic int rad_w(input int w, input int f);
    return term_w(w, f) - 1 + f - 2;
  endfunction

  // Bits of the square root result
  function automatic int root_w(input int w, input int f);
    return (rad_w(w, f) + 1) >> 1;
  endfunction

  // Quotient bits of the off-diagonal divide
  function automatic int quo_w(input int w);
    return w + 1;
  endfunction

  // Numerator bits: (|pair| << f) + 2*dom
  function automatic int num_w(input int w, input int f);
    return w + f + 2;
  endfunction

  // Remainder / compare width inside the divider
  function automatic int cmp_w(input int w, input int f);
    int a;
    int b;
    a = num_w(w, f);
    b = root_w(w, f) + 2 + quo_w(w);
    return (a > b) ? a : b;
  endfunction

endpackage

/* design/rotation_matrix_to_quaternion.sv */
// Path: front stages, ROOT_W square root stages, divide stages, output register, with
//   ROOT_W = ceil((max(DATA_WIDTH, FRAC_BITS+1) + FRAC_BITS - 1) / 2).
// Throughput: one transaction per cycle; every stage is a register, the whole pipe
//   advances unless the output register holds a result that is stalled.
// Reset: synchronous, active low rst_n clears all valid bits; data registers are not reset.
// Top level: rotation matrix to quaternion (Shepperd's method), fixed point.
module rotation_matrix_to_quaternion #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH,
  parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_m00, in_m01, in_m02,
  input  logic signed [DATA_WIDTH-1:0] in_m10, in_m11, in_m12,
  input  logic signed [DATA_WIDTH-1:0] in_m20, in_m21, in_m22,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_qx,
  output logic signed [DATA_WIDTH-1:0] out_qy,
  output logic signed [DATA_WIDTH-1:0] out_qz,
  output logic signed [DATA_WIDTH-1:0] out_qw,
  output logic                         out_invalid
);

  localparam int W   = DATA_WIDTH;
  localparam int NL  = rmq_pkg::NUM_LANES;
  localparam int R   = rmq_pkg::root_w(DATA_WIDTH, FRAC_BITS);
  localparam int QW  = rmq_pkg::quo_w(DATA_WIDTH);
  localparam int SQW = 1 + 2 + NL * (W + 1) + NL;
  localparam int DVW = 1 + 2 + R + NL;
  localparam int CMW = R + W;
  localparam logic [W-1:0]         POS_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [QW:0]   SAT_HI  = {2'b00, {(W-1){1'b1}}};
  localparam logic signed [QW:0]   SAT_LO  = {3'b111, {(W-2){1'b0}}, 1'b0};

  // Global advance: stop only when the output register is full and stalled
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // Front stages
  logic                  fr_valid;
  logic [2*R-1:0]        fr_rad;
  logic                  fr_invalid;
  rmq_pkg::big_t         fr_big;
  logic [W:0]            fr_mag [NL];
  logic [NL-1:0]         fr_sgn;

  rmq_front #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst_n, .en,
    .in_valid (in_valid),
    .m00 (in_m00), .m01 (in_m01), .m02 (in_m02),
    .m10 (in_m10), .m11 (in_m11), .m12 (in_m12),
    .m20 (in_m20), .m21 (in_m21), .m22 (in_m22),
    .out_valid   (fr_valid),
    .out_rad     (fr_rad),
    .out_invalid (fr_invalid),
    .out_big     (fr_big),
    .out_mag     (fr_mag),
    .out_sgn     (fr_sgn)
  );

  // Square root, pairs ride along
  logic [SQW-1:0] sq_sb_in, sq_sb_out;
  logic           sq_valid;
  logic [R-1:0]   sq_root;
  logic [W:0]     sq_mag [NL];

  assign sq_sb_in = {fr_invalid, fr_big, fr_mag[2], fr_mag[1], fr_mag[0], fr_sgn};

  rmq_sqrt #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS), .SB_WIDTH(SQW)) u_sqrt (
    .clk, .rst_n, .en,
    .in_valid  (fr_valid),
    .in_rad    (fr_rad),
    .in_sb     (sq_sb_in),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_sb    (sq_sb_out)
  );

  for (genvar l = 0; l < NL; l++) begin : g_sqmag
    assign sq_mag[l] = sq_sb_out[NL + l*(W+1) +: W+1];
  end

  // Divide lanes
  logic [DVW-1:0] dv_sb_in, dv_sb_out;
  logic           dv_valid;
  logic [QW-1:0]  dv_quo [NL];

  assign dv_sb_in = {sq_sb_out[SQW-1 -: 3], sq_root, sq_sb_out[NL-1:0]};

  rmq_div #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS), .SB_WIDTH(DVW)) u_div (
    .clk, .rst_n, .en,
    .in_valid  (sq_valid),
    .in_mag    (sq_mag),
    .in_dom    (sq_root),
    .in_sb     (dv_sb_in),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_sb    (dv_sb_out)
  );

  logic            dv_invalid;
  rmq_pkg::big_t   dv_big;
  logic [R-1:0]    dv_dom;
  logic [NL-1:0]   dv_sgn;

  assign dv_invalid = dv_sb_out[DVW-1];
  assign dv_big     = rmq_pkg::big_t'(dv_sb_out[DVW-2 -: 2]);
  assign dv_dom     = dv_sb_out[NL +: R];
  assign dv_sgn     = dv_sb_out[NL-1:0];

  // Sign, saturate, place the dominant component
  logic [W-1:0]       dom_sat;
  logic signed [QW:0] lval [NL];
  logic [W-1:0]       lsat [NL];
  logic [W-1:0]       comp [4];

  assign dom_sat = (CMW'(dv_dom) > CMW'(POS_MAX)) ? POS_MAX : W'(dv_dom);

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      lval[l] = dv_sgn[l] ? -$signed({1'b0, dv_quo[l]}) : $signed({1'b0, dv_quo[l]});
      if (dv_dom == '0) begin
        lsat[l] = '0;
      end else if (lval[l] > SAT_HI) begin
        lsat[l] = SAT_HI[W-1:0];
      end else if (lval[l] < SAT_LO) begin
        lsat[l] = SAT_LO[W-1:0];
      end else begin
        lsat[l] = lval[l][W-1:0];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (dv_invalid) begin
        comp[k] = '0;
      end else if (k < int'(dv_big)) begin
        comp[k] = lsat[k];
      end else if (k == int'(dv_big)) begin
        comp[k] = dom_sat;
      end else begin
        comp[k] = lsat[k-1];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_qx      <= comp[0];
      out_qy      <= comp[1];
      out_qz      <= comp[2];
      out_qw      <= comp[3];
      out_invalid <= dv_invalid;
    end
  end

  // The four terms sum to four, so the largest is never negative
  a_never_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_invalid)
    else $error("invalid flag raised on a result");

  // A full, stalled output register holds the whole pipe
  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("input accepted while output stalled");

  // Reset empties the output
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // The dominant component is never zero on a valid result
  a_dom_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    dv_valid |-> (dv_dom != '0))
    else $error("zero dominant component");

endmodule

/* design/rmq_front.sv */
// Front stages: candidate terms, off-diagonal pairs, winner select and radicand.
module rmq_front #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH,
  parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic signed [DATA_WIDTH-1:0]          m00, m01, m02,
  input  logic signed [DATA_WIDTH-1:0]          m10, m11, m12,
  input  logic signed [DATA_WIDTH-1:0]          m20, m21, m22,
  output logic                                  out_valid,
  output logic [2*rmq_pkg::root_w(DATA_WIDTH, FRAC_BITS)-1:0] out_rad,
  output logic                                  out_invalid,
  output rmq_pkg::big_t                         out_big,
  output logic [DATA_WIDTH:0]                   out_mag [rmq_pkg::NUM_LANES],
  output logic [rmq_pkg::NUM_LANES-1:0]         out_sgn
);

  localparam int TW = rmq_pkg::term_w(DATA_WIDTH, FRAC_BITS);
  localparam int RW = 2 * rmq_pkg::root_w(DATA_WIDTH, FRAC_BITS);
  localparam int PW = DATA_WIDTH + 1;
  localparam logic signed [TW-1:0] ONE = TW'(1) << FRAC_BITS;

  // Stage 1: terms and pairs
  logic                 v1_r;
  logic signed [TW-1:0] t_r [4];
  logic signed [PW-1:0] a01_r, a20_r, a12_r, d12_r, d20_r, d01_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r[0] <= TW'(m00) - TW'(m11) - TW'(m22) + ONE;
      t_r[1] <= TW'(m11) - TW'(m00) - TW'(m22) + ONE;
      t_r[2] <= TW'(m22) - TW'(m00) - TW'(m11) + ONE;
      t_r[3] <= TW'(m00) + TW'(m11) + TW'(m22) + ONE;
      a01_r  <= PW'(m01) + PW'(m10);
      a20_r  <= PW'(m20) + PW'(m02);
      a12_r  <= PW'(m12) + PW'(m21);
      d12_r  <= PW'(m12) - PW'(m21);
      d20_r  <= PW'(m20) - PW'(m02);
      d01_r  <= PW'(m01) - PW'(m10);
    end
  end

  // Winner select, first index wins ties
  rmq_pkg::big_t        big;
  logic signed [TW-1:0] tmax;
  logic signed [PW-1:0] lane [rmq_pkg::NUM_LANES];

  always_comb begin
    big  = rmq_pkg::BIG_X;
    tmax = t_r[0];
    if (t_r[1] > tmax) begin
      big  = rmq_pkg::BIG_Y;
      tmax = t_r[1];
    end
    if (t_r[2] > tmax) begin
      big  = rmq_pkg::BIG_Z;
      tmax = t_r[2];
    end
    if (t_r[3] > tmax) begin
      big  = rmq_pkg::BIG_W;
      tmax = t_r[3];
    end
  end

  // Non-dominant pairs in x, y, z, w order
  always_comb begin
    case (big)
      rmq_pkg::BIG_X: begin
        lane[0] = a01_r; lane[1] = a20_r; lane[2] = d12_r;
      end
      rmq_pkg::BIG_Y: begin
        lane[0] = a01_r; lane[1] = a12_r; lane[2] = d20_r;
      end
      rmq_pkg::BIG_Z: begin
        lane[0] = a20_r; lane[1] = a12_r; lane[2] = d01_r;
      end
      default: begin
        lane[0] = d12_r; lane[1] = d20_r; lane[2] = d01_r;
      end
    endcase
  end

  // Stage 2: radicand, sign and magnitude
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_invalid <= tmax[TW-1];
      out_big     <= big;
      out_rad     <= RW'({tmax[TW-2:0], {(FRAC_BITS-2){1'b0}}});
      for (int l = 0; l < rmq_pkg::NUM_LANES; l++) begin
        out_sgn[l] <= lane[l][PW-1];
        out_mag[l] <= lane[l][PW-1] ? PW'(-lane[l]) : PW'(lane[l]);
      end
    end
  end

endmodule

/* design/rmq_sqrt.sv */
// Pipelined restoring integer square root, one result bit per stage.
module rmq_sqrt #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH,
  parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS,
  parameter int SB_WIDTH   = 1
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            en,
  input  logic                                            in_valid,
  input  logic [2*rmq_pkg::root_w(DATA_WIDTH, FRAC_BITS)-1:0] in_rad,
  input  logic [SB_WIDTH-1:0]                             in_sb,
  output logic                                            out_valid,
  output logic [rmq_pkg::root_w(DATA_WIDTH, FRAC_BITS)-1:0]   out_root,
  output logic [SB_WIDTH-1:0]                             out_sb
);

  localparam int R   = rmq_pkg::root_w(DATA_WIDTH, FRAC_BITS);
  localparam int RMW = R + 3;

  logic            v_r    [R];
  logic [2*R-1:0]  rad_r  [R];
  logic [RMW-1:0]  rem_r  [R];
  logic [R-1:0]    root_r [R];
  logic [SB_WIDTH-1:0] sb_r [R];

  for (genvar s = 0; s < R; s++) begin : g_stage
    logic            v_in;
    logic [2*R-1:0]  rad_in;
    logic [RMW-1:0]  rem_in;
    logic [R-1:0]    root_in;
    logic [SB_WIDTH-1:0] sb_in;
    logic [RMW-1:0]  rem_sh;
    logic [RMW-1:0]  trial;
    logic            take;

    if (s == 0) begin : g_first
      assign v_in    = in_valid;
      assign rad_in  = in_rad;
      assign rem_in  = '0;
      assign root_in = '0;
      assign sb_in   = in_sb;
    end else begin : g_next
      assign v_in    = v_r[s-1];
      assign rad_in  = rad_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
      assign sb_in   = sb_r[s-1];
    end

    // Bring down two radicand bits, try subtracting 4*root+1
    assign rem_sh = {rem_in[RMW-3:0], rad_in[2*R-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[s]  <= rad_in << 2;
        rem_r[s]  <= take ? (rem_sh - trial) : rem_sh;
        root_r[s] <= {root_in[R-2:0], take};
        sb_r[s]   <= sb_in;
      end
    end
  end

  assign out_valid = v_r[R-1];
  assign out_root  = root_r[R-1];
  assign out_sb    = sb_r[R-1];

endmodule

/* design/rmq_div.sv */
// Pipelined rounding divider for the three non-dominant components, one quotient bit per stage.
module rmq_div #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH,
  parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS,
  parameter int SB_WIDTH   = 1
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          en,
  input  logic                                          in_valid,
  input  logic [DATA_WIDTH:0]                           in_mag [rmq_pkg::NUM_LANES],
  input  logic [rmq_pkg::root_w(DATA_WIDTH, FRAC_BITS)-1:0] in_dom,
  input  logic [SB_WIDTH-1:0]                           in_sb,
  output logic                                          out_valid,
  output logic [rmq_pkg::quo_w(DATA_WIDTH)-1:0]         out_quo [rmq_pkg::NUM_LANES],
  output logic [SB_WIDTH-1:0]                           out_sb
);

  localparam int R  = rmq_pkg::root_w(DATA_WIDTH, FRAC_BITS);
  localparam int QW = rmq_pkg::quo_w(DATA_WIDTH);
  localparam int NW = rmq_pkg::num_w(DATA_WIDTH, FRAC_BITS);
  localparam int CW = rmq_pkg::cmp_w(DATA_WIDTH, FRAC_BITS);
  localparam int NL = rmq_pkg::NUM_LANES;

  // Stage 0 prepares the rounded numerator; stages 1..QW resolve one bit each
  logic            v_r   [QW+1];
  logic [R+1:0]    den_r [QW+1];
  logic [CW-1:0]   rem_r [QW+1][NL];
  logic [QW-1:0]   quo_r [QW+1][NL];
  logic [SB_WIDTH-1:0] sb_r [QW+1];

  // Numerator setup
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0] <= {in_dom, 2'b00};
      sb_r[0]  <= in_sb;
      for (int l = 0; l < NL; l++) begin
        rem_r[0][l] <= CW'(NW'({in_mag[l], {FRAC_BITS{1'b0}}}) + NW'({in_dom, 1'b0}));
        quo_r[0][l] <= '0;
      end
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_stage
    localparam int BIT = QW - s;
    logic [CW-1:0] dsh;

    assign dsh = CW'(den_r[s-1]) << BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_r[s-1];
      end
    end

    // Restoring step per lane
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[s] <= den_r[s-1];
        sb_r[s]  <= sb_r[s-1];
        for (int l = 0; l < NL; l++) begin
          if (rem_r[s-1][l] >= dsh) begin
            rem_r[s][l] <= rem_r[s-1][l] - dsh;
            quo_r[s][l] <= quo_r[s-1][l] | (QW'(1) << BIT);
          end else begin
            rem_r[s][l] <= rem_r[s-1][l];
            quo_r[s][l] <= quo_r[s-1][l];
          end
        end
      end
    end
  end

  assign out_valid = v_r[QW];
  assign out_sb    = sb_r[QW];
  for (genvar l = 0; l < NL; l++) begin : g_out
    assign out_quo[l] = quo_r[QW][l];
  end

endmodule
